/* hdl/babi_pkg.sv */
// Shared types and constants for the block average brightness index design.
`default_nettype none
package babi_pkg;

   // Fixed field and accumulator widths
   localparam int SUM_W = 20;
   localparam int TOT_W = 22;
   localparam int CNT_W = 17;

   // Register indexes on the configuration port
   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH     = 3'd0,
      REG_IMAGE_HEIGHT    = 3'd1,
      REG_BLOCK_WIDTH     = 3'd2,
      REG_BLOCK_HEIGHT    = 3'd3,
      REG_BRIGHTNESS_STEP = 3'd4,
      REG_CHAR_COUNT      = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [7:0] avg_red;
      logic [7:0] avg_green;
      logic [7:0] avg_blue;
      logic [9:0] brightness;
      logic [5:0] char_index;
      logic       row_end;
      logic       frame_end;
   } result_type;

   typedef struct packed {
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic [6:0]  block_width;
      logic [6:0]  block_height;
      logic [9:0]  brightness_step;
      logic [6:0]  char_count;
   } cfg_type;

   // One finished cell, handed from the front to the back
   typedef struct packed {
      logic [SUM_W-1:0] sum_red;
      logic [SUM_W-1:0] sum_green;
      logic [SUM_W-1:0] sum_blue;
      logic [CNT_W-1:0] count;
      logic             row_end;
      logic             frame_end;
   } job_type;

endpackage
`default_nettype wire

/* hdl/block_average_brightness_index_top.sv */
// Top level: configuration registers, front, job queue and back.
// Path: a cell's last pixel passes the sum update, the job queue, the channel divide,
// the step divide and the output register before it reaches rsp_valid.
// The front takes no new pixel while the read-modify-write of the sum memory is pending;
// the back takes no new cell until its bit-serial dividers have finished the current one.
// Reset clears positions, queue and handshake state and loads register defaults;
// the sum memory needs no clearing since each cell's first pixel ignores the entry.
`default_nettype none
module block_average_brightness_index_top #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_BLOCK = 64
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  babi_pkg::pixel_type  req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output babi_pkg::result_type rsp_data,
   input  wire                  psel,
   input  wire                  penable,
   input  wire                  pwrite,
   input  wire  [4:0]           paddr,
   input  wire  [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   babi_pkg::cfg_type cfg_ff;
   babi_pkg::reg_index_type ridx;
   babi_pkg::job_type push_job, pop_job;
   logic wr_en, q_full, q_push, q_empty, q_pop;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign ridx   = babi_pkg::reg_index_type'(paddr[4:2]);

   // Write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width     <= 13'd640;
         cfg_ff.image_height    <= 13'd480;
         cfg_ff.block_width     <= 7'd8;
         cfg_ff.block_height    <= 7'd8;
         cfg_ff.brightness_step <= 10'd64;
         cfg_ff.char_count      <= 7'd12;
      end else if (wr_en) begin
         unique case (ridx)
            babi_pkg::REG_IMAGE_WIDTH:     cfg_ff.image_width     <= pwdata[12:0];
            babi_pkg::REG_IMAGE_HEIGHT:    cfg_ff.image_height    <= pwdata[12:0];
            babi_pkg::REG_BLOCK_WIDTH:     cfg_ff.block_width     <= pwdata[6:0];
            babi_pkg::REG_BLOCK_HEIGHT:    cfg_ff.block_height    <= pwdata[6:0];
            babi_pkg::REG_BRIGHTNESS_STEP: cfg_ff.brightness_step <= pwdata[9:0];
            babi_pkg::REG_CHAR_COUNT:      cfg_ff.char_count      <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (ridx)
         babi_pkg::REG_IMAGE_WIDTH:     prdata = 32'(cfg_ff.image_width);
         babi_pkg::REG_IMAGE_HEIGHT:    prdata = 32'(cfg_ff.image_height);
         babi_pkg::REG_BLOCK_WIDTH:     prdata = 32'(cfg_ff.block_width);
         babi_pkg::REG_BLOCK_HEIGHT:    prdata = 32'(cfg_ff.block_height);
         babi_pkg::REG_BRIGHTNESS_STEP: prdata = 32'(cfg_ff.brightness_step);
         babi_pkg::REG_CHAR_COUNT:      prdata = 32'(cfg_ff.char_count);
         default:                       prdata = '0;
      endcase
   end

   babi_front #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_BLOCK(MAX_BLOCK)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   babi_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_job  (pop_job)
   );

   babi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_job     (pop_job),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* hdl/babi_front.sv */
// Front: pixel intake, raster position tracking and per-column sum memory.
`default_nettype none
module babi_front #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_BLOCK = 64
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  babi_pkg::pixel_type  req_data,
   input  babi_pkg::cfg_type    cfg,
   input  wire                  q_full,
   output logic                 q_push,
   output babi_pkg::job_type    q_job
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int BW = $clog2(MAX_BLOCK);
   localparam int SW = babi_pkg::SUM_W;

   logic [CW-1:0]   col_ff, col_in, bcol_ff, bcol_in;
   logic [11:0]     row_ff, row_in;
   logic [BW-1:0]   cib_ff, cib_in, rib_ff, rib_in;

   logic            p_valid_ff;
   babi_pkg::pixel_type pix_ff;
   logic [CW-1:0]   idx_ff;
   logic            fresh_ff, done_ff, rlast_ff, flast_ff;
   logic [BW-1:0]   pcib_ff, prib_ff;

   logic [3*SW-1:0] mem [MAX_WIDTH];
   logic [3*SW-1:0] rd_ff;

   logic [CW-1:0]   wm1;
   logic [11:0]     hm1;
   logic [BW-1:0]   bwm1, bhm1;
   logic [15:0]     iw16;
   logic [8:0]      bw9, bh9;
   logic            accept, row_last, frame_last, ccol_last, crow_last;
   logic [SW-1:0]   s_r, s_g, s_b, o_r, o_g, o_b;
   logic [babi_pkg::CNT_W-1:0] n_c, n_r;
   logic [2*babi_pkg::CNT_W-1:0] n_prod;

   // Clamp the geometry registers into their usable ranges, minus one
   always_comb begin
      iw16 = {3'b0, cfg.image_width};
      bw9  = {2'b0, cfg.block_width};
      bh9  = {2'b0, cfg.block_height};
      if (iw16 == 16'd0) begin
         wm1 = '0;
      end else if (iw16 > 16'(MAX_WIDTH)) begin
         wm1 = CW'(MAX_WIDTH - 1);
      end else begin
         wm1 = CW'(iw16 - 16'd1);
      end
      if (cfg.image_height == 13'd0) begin
         hm1 = '0;
      end else if (cfg.image_height > 13'd4096) begin
         hm1 = 12'd4095;
      end else begin
         hm1 = 12'(cfg.image_height - 13'd1);
      end
      if (bw9 == 9'd0) begin
         bwm1 = '0;
      end else if (bw9 > 9'(MAX_BLOCK)) begin
         bwm1 = BW'(MAX_BLOCK - 1);
      end else begin
         bwm1 = BW'(bw9 - 9'd1);
      end
      if (bh9 == 9'd0) begin
         bhm1 = '0;
      end else if (bh9 > 9'(MAX_BLOCK)) begin
         bhm1 = BW'(MAX_BLOCK - 1);
      end else begin
         bhm1 = BW'(bh9 - 9'd1);
      end
   end

   // Take a pixel only when no update is pending and the queue has room
   assign req_stall  = p_valid_ff || q_full;
   assign accept     = req_valid && !req_stall;
   assign row_last   = col_ff >= wm1;
   assign frame_last = row_ff >= hm1;
   assign ccol_last  = row_last || (cib_ff >= bwm1);
   assign crow_last  = frame_last || (rib_ff >= bhm1);

   // Advance the raster position
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      cib_in  = cib_ff;
      rib_in  = rib_ff;
      bcol_in = bcol_ff;
      if (accept) begin
         if (row_last) begin
            col_in  = '0;
            cib_in  = '0;
            bcol_in = '0;
            if (frame_last) begin
               row_in = '0;
               rib_in = '0;
            end else begin
               row_in = row_ff + 12'd1;
               rib_in = (rib_ff >= bhm1) ? '0 : rib_ff + BW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
            if (cib_ff >= bwm1) begin
               cib_in  = '0;
               bcol_in = bcol_ff + CW'(1);
            end else begin
               cib_in = cib_ff + BW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         cib_ff     <= '0;
         rib_ff     <= '0;
         bcol_ff    <= '0;
         p_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         cib_ff     <= cib_in;
         rib_ff     <= rib_in;
         bcol_ff    <= bcol_in;
         p_valid_ff <= accept;
      end
   end

   // Hold the pixel and its cell flags for the update cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff   <= req_data;
         idx_ff   <= bcol_ff;
         fresh_ff <= (cib_ff == '0) && (rib_ff == '0);
         done_ff  <= ccol_last && crow_last;
         rlast_ff <= row_last;
         flast_ff <= row_last && frame_last;
         pcib_ff  <= cib_ff;
         prib_ff  <= rib_ff;
      end
   end

   // Sum memory: read on transfer, write back in the cycle after
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[bcol_ff];
      end
      if (p_valid_ff) begin
         mem[idx_ff] <= {s_r, s_g, s_b};
      end
   end

   // Add the pixel; the first pixel of a cell ignores the stale entry
   always_comb begin
      o_r = fresh_ff ? '0 : rd_ff[3*SW-1:2*SW];
      o_g = fresh_ff ? '0 : rd_ff[2*SW-1:SW];
      o_b = fresh_ff ? '0 : rd_ff[SW-1:0];
      s_r = o_r + SW'(pix_ff.red);
      s_g = o_g + SW'(pix_ff.green);
      s_b = o_b + SW'(pix_ff.blue);
      n_c = babi_pkg::CNT_W'(pcib_ff) + babi_pkg::CNT_W'(1);
      n_r = babi_pkg::CNT_W'(prib_ff) + babi_pkg::CNT_W'(1);
      n_prod = n_c * n_r;
   end

   assign q_push          = p_valid_ff && done_ff;
   assign q_job.sum_red   = s_r;
   assign q_job.sum_green = s_g;
   assign q_job.sum_blue  = s_b;
   assign q_job.count     = n_prod[babi_pkg::CNT_W-1:0];
   assign q_job.row_end   = rlast_ff;
   assign q_job.frame_end = flast_ff;

   a_no_accept_in_update: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> req_stall)
      else $error("pixel taken while a sum update is pending");

endmodule
`default_nettype wire

/* hdl/babi_queue.sv */
// Short job queue between the front and the back.
`default_nettype none
module babi_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  babi_pkg::job_type  push_job,
   output logic               full,
   input  wire                pop,
   output logic               empty,
   output babi_pkg::job_type  pop_job
);

   localparam int DEPTH = 4;

   babi_pkg::job_type entry_ff [DEPTH];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;

   assign full    = cnt_ff == 3'(DEPTH);
   assign empty   = cnt_ff == 3'd0;
   assign pop_job = entry_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 2'd1 : wp_ff;
      rp_in  = pop ? rp_ff + 2'd1 : rp_ff;
      cnt_in = cnt_ff + 3'(push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wp_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("job queue underflow");

endmodule
`default_nettype wire

/* hdl/babi_back.sv */
// Back: shared bit-serial dividers for the averages and the character index.
`default_nettype none
module babi_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  q_empty,
   output logic                 q_pop,
   input  babi_pkg::job_type    q_job,
   input  babi_pkg::cfg_type    cfg,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output babi_pkg::result_type rsp_data
);

   localparam int TW = babi_pkg::TOT_W;
   localparam int NW = babi_pkg::CNT_W;

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_DIV  = 4'b0010,
      B_STEP = 4'b0100,
      B_OUT  = 4'b1000
   } bstate_type;

   bstate_type state_ff, state_in;
   logic [4:0]     it_ff, it_in;
   logic [TW-1:0]  dvd_ff [4];
   logic [TW-1:0]  dvd_in [4];
   logic [NW-1:0]  rem_ff [4];
   logic [NW-1:0]  rem_in [4];
   logic [NW-1:0]  div_ff;
   logic [9:0]     q2_ff, q2_in, r2_ff, r2_in;
   logic           rend_ff, fend_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   babi_pkg::result_type rsp_ff, rsp_in;

   logic [NW:0]    trial [4];
   logic [10:0]    trial2;
   logic [9:0]     step, ccm1, idx;
   logic [6:0]     cc;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == B_IDLE) && !q_empty;
   assign step      = (cfg.brightness_step == 10'd0) ? 10'd1 : cfg.brightness_step;

   always_comb begin
      if (cfg.char_count == 7'd0) begin
         cc = 7'd1;
      end else if (cfg.char_count > 7'd64) begin
         cc = 7'd64;
      end else begin
         cc = cfg.char_count;
      end
      ccm1 = 10'(cc - 7'd1);
      idx  = (q2_ff > ccm1) ? ccm1 : q2_ff;
   end

   // Load a job, take one quotient bit per cycle on each of the four lanes, then the step divide, then the result
   always_comb begin
      state_in     = state_ff;
      it_in        = it_ff;
      q2_in        = q2_ff;
      r2_in        = r2_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      trial2       = {r2_ff, q2_ff[9]};
      for (int i = 0; i < 4; i++) begin
         dvd_in[i] = dvd_ff[i];
         rem_in[i] = rem_ff[i];
         trial[i]  = {rem_ff[i], dvd_ff[i][TW-1]};
      end
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               dvd_in[0] = TW'(q_job.sum_red);
               dvd_in[1] = TW'(q_job.sum_green);
               dvd_in[2] = TW'(q_job.sum_blue);
               dvd_in[3] = TW'(q_job.sum_red) + TW'(q_job.sum_green)
                           + TW'(q_job.sum_blue);
               for (int i = 0; i < 4; i++) begin
                  rem_in[i] = '0;
               end
               it_in    = '0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            for (int i = 0; i < 4; i++) begin
               if (trial[i] >= {1'b0, div_ff}) begin
                  rem_in[i] = NW'(trial[i] - {1'b0, div_ff});
                  dvd_in[i] = {dvd_ff[i][TW-2:0], 1'b1};
               end else begin
                  rem_in[i] = trial[i][NW-1:0];
                  dvd_in[i] = {dvd_ff[i][TW-2:0], 1'b0};
               end
            end
            if (it_ff == 5'(TW - 1)) begin
               it_in    = '0;
               state_in = B_STEP;
               q2_in    = dvd_in[3][9:0];
               r2_in    = '0;
            end else begin
               it_in = it_ff + 5'd1;
            end
         end
         B_STEP: begin
            if (trial2 >= {1'b0, step}) begin
               r2_in = 10'(trial2 - {1'b0, step});
               q2_in = {q2_ff[8:0], 1'b1};
            end else begin
               r2_in = trial2[9:0];
               q2_in = {q2_ff[8:0], 1'b0};
            end
            if (it_ff == 5'd9) begin
               state_in = B_OUT;
            end else begin
               it_in = it_ff + 5'd1;
            end
         end
         B_OUT: begin
            if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.avg_red      = dvd_ff[0][7:0];
               rsp_in.avg_green    = dvd_ff[1][7:0];
               rsp_in.avg_blue     = dvd_ff[2][7:0];
               rsp_in.brightness   = dvd_ff[3][9:0];
               rsp_in.char_index   = idx[5:0];
               rsp_in.row_end      = rend_ff;
               rsp_in.frame_end    = fend_ff;
               state_in            = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      it_ff  <= it_in;
      q2_ff  <= q2_in;
      r2_ff  <= r2_in;
      rsp_ff <= rsp_in;
      for (int i = 0; i < 4; i++) begin
         dvd_ff[i] <= dvd_in[i];
         rem_ff[i] <= rem_in[i];
      end
      if (q_pop) begin
         div_ff  <= q_job.count;
         rend_ff <= q_job.row_end;
         fend_ff <= q_job.frame_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

/* dv/babi_checker.sv */
// Scoreboard for the block average brightness index design: predicts cells and checks results.
`default_nettype none
module babi_checker (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_stall,
   input  babi_pkg::pixel_type  req_data,
   input  wire                  rsp_valid,
   input  wire                  rsp_stall,
   input  babi_pkg::result_type rsp_data,
   input  wire                  psel,
   input  wire                  penable,
   input  wire                  pwrite,
   input  wire  [4:0]           paddr,
   input  wire  [31:0]          pwdata,
   input  wire                  pready,
   output int                   errors,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIDTH = 4096;
   localparam int MAX_BLOCK = 64;

   // Shadow registers and position state
   logic [12:0] img_w, img_h;
   logic [6:0]  blk_w, blk_h, chars;
   logic [9:0]  step_reg;
   logic [19:0] col_sum_red   [MAX_WIDTH];
   logic [19:0] col_sum_green [MAX_WIDTH];
   logic [19:0] col_sum_blue  [MAX_WIDTH];
   int unsigned col_pos, row_pos, col_in_cell, row_in_cell, cell_col;
   babi_pkg::result_type cell_q[$];
   int          err_cnt;

   function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Advance the position state by one pixel; queue a cell when it completes
   function automatic void predict_cell(babi_pkg::pixel_type px);
      int unsigned w, h, bw, bh, stp, cc, cnt, bright, idx;
      logic [19:0] sr, sg, sb;
      bit row_last, frame_last, col_last, rlast, fresh;
      babi_pkg::result_type exp_cell;
      w = clip(img_w, 1, MAX_WIDTH);
      h = clip(img_h, 1, 4096);
      bw = clip(blk_w, 1, MAX_BLOCK);
      bh = clip(blk_h, 1, MAX_BLOCK);
      stp = (step_reg == 0) ? 1 : step_reg;
      cc = clip(chars, 1, 64);
      row_last = col_pos >= w - 1;
      frame_last = row_pos >= h - 1;
      col_last = row_last || col_in_cell >= bw - 1;
      rlast = frame_last || row_in_cell >= bh - 1;
      fresh = col_in_cell == 0 && row_in_cell == 0;
      sr = 0;
      sg = 0;
      sb = 0;
      if (!fresh) begin
         sr = col_sum_red[cell_col];
         sg = col_sum_green[cell_col];
         sb = col_sum_blue[cell_col];
      end
      sr = sr + px.red;
      sg = sg + px.green;
      sb = sb + px.blue;
      col_sum_red[cell_col] = sr;
      col_sum_green[cell_col] = sg;
      col_sum_blue[cell_col] = sb;
      if (col_last && rlast) begin
         cnt = (col_in_cell + 1) * (row_in_cell + 1);
         bright = ((sr + sg + sb) / cnt) & 10'h3FF;
         idx = bright / stp;
         if (idx > cc - 1) idx = cc - 1;
         exp_cell.avg_red = sr / cnt;
         exp_cell.avg_green = sg / cnt;
         exp_cell.avg_blue = sb / cnt;
         exp_cell.brightness = bright;
         exp_cell.char_index = idx;
         exp_cell.row_end = row_last;
         exp_cell.frame_end = row_last && frame_last;
         cell_q.insert(cell_q.size(), exp_cell);
      end
      if (row_last) begin
         col_pos = 0;
         col_in_cell = 0;
         cell_col = 0;
         if (frame_last) begin
            row_pos = 0;
            row_in_cell = 0;
         end else begin
            row_pos++;
            row_in_cell = (row_in_cell >= bh - 1) ? 0 : row_in_cell + 1;
         end
      end else begin
         col_pos++;
         if (col_in_cell >= bw - 1) begin
            col_in_cell = 0;
            cell_col++;
         end else begin
            col_in_cell++;
         end
      end
   endfunction

   // Track register writes, predict on input transfers, compare on result transfers
   always @(posedge clock) begin
      babi_pkg::result_type want;
      if (reset) begin
         img_w = 640;
         img_h = 480;
         blk_w = 8;
         blk_h = 8;
         step_reg = 64;
         chars = 12;
         col_pos = 0;
         row_pos = 0;
         col_in_cell = 0;
         row_in_cell = 0;
         cell_col = 0;
         cell_q.delete();
         err_cnt = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (babi_pkg::reg_index_type'(paddr[4:2]))
               babi_pkg::REG_IMAGE_WIDTH:     img_w = pwdata[12:0];
               babi_pkg::REG_IMAGE_HEIGHT:    img_h = pwdata[12:0];
               babi_pkg::REG_BLOCK_WIDTH:     blk_w = pwdata[6:0];
               babi_pkg::REG_BLOCK_HEIGHT:    blk_h = pwdata[6:0];
               babi_pkg::REG_BRIGHTNESS_STEP: step_reg = pwdata[9:0];
               babi_pkg::REG_CHAR_COUNT:      chars = pwdata[6:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_cell(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (cell_q.size() == 0) begin
               err_cnt++;
               if (err_cnt <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               want = cell_q.pop_front();
               if (want.avg_red !== rsp_data.avg_red || want.avg_green !== rsp_data.avg_green
                   || want.avg_blue !== rsp_data.avg_blue
                   || want.brightness !== rsp_data.brightness
                   || want.char_index !== rsp_data.char_index
                   || want.row_end !== rsp_data.row_end
                   || want.frame_end !== rsp_data.frame_end) begin
                  err_cnt++;
                  if (err_cnt <= 10)
                     $display("cell mismatch: expected %p actual %p", want, rsp_data);
               end
            end
         end
      end
      errors <= err_cnt;
      pending <= cell_q.size();
   end

endmodule
`default_nettype wire

/* dv/block_average_brightness_index_top_tb.sv */
// Testbench top: clock, reset, pixel and register stimulus, and the verdict.
`default_nettype none
module block_average_brightness_index_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_CYCLES = 80;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   babi_pkg::pixel_type  req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   babi_pkg::result_type rsp_data;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          errors, pending;
   int          tx_idle_pct = 0, rx_stall_pct = 0;
   bit          want_hold = 0;
   int          held = 0;
   int          cycles = 0;
   int          rand_pixels = 0;

   block_average_brightness_index_top DUT (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   babi_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .pending
   );

   always #10 clock = ~clock;

   // Stall the result side at random; hold off for a long stretch once when asked
   always @(posedge clock) begin
      if (want_hold && held < 600) begin
         rsp_stall <= 1;
         held <= held + 1;
      end else begin
         rsp_stall <= $urandom_range(99) < rx_stall_pct;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("block_average_brightness_index_top regression: fail");
         $finish;
      end
   end

   task automatic write_reg(babi_pkg::reg_index_type idx, logic [31:0] value);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   // Drop valid, wait for every expected cell, then let the back drain before a write
   task automatic setup_frame(int w, int h, int bw, int bh, int stp, int cc);
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(babi_pkg::REG_IMAGE_WIDTH, w);
      write_reg(babi_pkg::REG_IMAGE_HEIGHT, h);
      write_reg(babi_pkg::REG_BLOCK_WIDTH, bw);
      write_reg(babi_pkg::REG_BLOCK_HEIGHT, bh);
      write_reg(babi_pkg::REG_BRIGHTNESS_STEP, stp);
      write_reg(babi_pkg::REG_CHAR_COUNT, cc);
   endtask

   // Offer one pixel, hold it until the transfer, then maybe idle
   task automatic send_pixel(babi_pkg::pixel_type px);
      req_valid <= 1;
      req_data <= px;
      do @(posedge clock); while (req_stall);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
   endtask

   function automatic logic [7:0] pick_level();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return $urandom_range(255);
      endcase
   endfunction

   function automatic babi_pkg::pixel_type pick_pixel();
      babi_pkg::pixel_type px;
      case ($urandom_range(9))
         0: px = '0;
         1: px = '1;
         default: px = {pick_level(), pick_level(), pick_level()};
      endcase
      return px;
   endfunction

   // Send one whole frame of random pixels
   task automatic send_frame(int pixels);
      for (int i = 0; i < pixels; i++) send_pixel(pick_pixel());
   endtask

   function automatic int pick_dim(int lo, int hi);
      int v;
      v = $urandom_range(19);
      if (v == 0) return 0;
      if (v == 1) return 127;
      return $urandom_range(hi, lo);
   endfunction

   initial begin
      int w, h, bw, bh, ew, eh, stp, cc;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Extremes: black, white and single channels in 2x2 cells
      setup_frame(4, 2, 2, 2, 64, 12);
      send_pixel('0);
      send_pixel('1);
      send_pixel({8'hFF, 8'h00, 8'h00});
      send_pixel({8'h00, 8'hFF, 8'h00});
      send_pixel({8'h00, 8'h00, 8'hFF});
      send_pixel('1);
      send_pixel('1);
      send_pixel({8'h01, 8'h80, 8'h7F});
      // Partial edge cells, zero step and zero character count
      setup_frame(3, 3, 2, 2, 0, 0);
      send_frame(9);
      // Zero sizes act as one, oversized cell, largest step and count
      setup_frame(0, 0, 127, 0, 1023, 127);
      send_pixel('1);
      // One-pixel cells, unit step, full character set
      setup_frame(5, 1, 1, 1, 1, 64);
      send_frame(5);
      // Widest cell and oversized cell height
      setup_frame(64, 1, 64, 64, 765, 64);
      send_frame(64);
      setup_frame(1, 64, 1, 127, 3, 127);
      send_frame(64);

      // Random frames in three idle phases
      while (rand_pixels < 1650) begin
         if (rand_pixels >= 1100 && tx_idle_pct != 0) begin
            tx_idle_pct = 0;
            rx_stall_pct = 0;
            // Fill the block with one-pixel cells while the result side holds off
            setup_frame(16, 8, 1, 1, 40, 20);
            want_hold = 1;
            send_frame(128);
            rand_pixels += 128;
         end else if (rand_pixels >= 550 && rand_pixels < 1100) begin
            tx_idle_pct = 80;
            rx_stall_pct = 9;
         end else if (rand_pixels < 550) begin
            tx_idle_pct = 9;
            rx_stall_pct = 80;
         end
         w = pick_dim(1, 24);
         h = pick_dim(1, 10);
         bw = ($urandom_range(9) == 0) ? pick_dim(1, 64) : $urandom_range(8, 1);
         bh = ($urandom_range(9) == 0) ? pick_dim(1, 64) : $urandom_range(8, 1);
         stp = $urandom_range(1023);
         cc = $urandom_range(127);
         if (w == 127) w = 8191 - $urandom_range(4095) & 13'h1FC0 | 13'd20;
         ew = (w == 0) ? 1 : ((w > 4096) ? 4096 : w);
         if (ew > 64) begin
            w = 24;
            ew = 24;
         end
         if (h == 127) h = 12;
         eh = (h == 0) ? 1 : h;
         setup_frame(w, h, bw, bh, stp, cc);
         send_frame(ew * eh);
         rand_pixels += ew * eh;
      end
      req_valid <= 0;

      // Drain and decide
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("block_average_brightness_index_top regression: pass");
      end else begin
         $display("block_average_brightness_index_top regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
hdl/babi_pkg.sv
hdl/babi_front.sv
hdl/babi_queue.sv
hdl/babi_back.sv
hdl/block_average_brightness_index_top.sv
dv/babi_checker.sv
dv/block_average_brightness_index_top_tb.sv
